### hw/rtl/akfc_pkg.sv
// shared types, constants and the crc byte step for the ack frame checker
package akfc_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned CRC_W           = 16;
    localparam int unsigned ADDR_W          = 4;
    localparam int unsigned APB_DATA_W      = 32;
    localparam int unsigned IN_DATA_W       = 16;
    localparam int unsigned OUT_DATA_W      = 16;

    localparam logic [CRC_W-1:0]  CRC_INIT        = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY        = 16'h1021;
    localparam logic [BYTE_W-1:0] MIN_FRAME_BYTES = 8'd8;
    localparam logic [BYTE_W-1:0] HEADER_BYTES    = 8'd6;
    localparam logic [BYTE_W-1:0] COUNT_MAX       = 8'hFF;
    localparam logic [BYTE_W-1:0] PAD_BYTE        = 8'h00;

    // header byte positions
    localparam logic [BYTE_W-1:0] POS_MAGIC    = 8'd0;
    localparam logic [BYTE_W-1:0] POS_VERSION  = 8'd1;
    localparam logic [BYTE_W-1:0] POS_ACK_TYPE = 8'd2;
    localparam logic [BYTE_W-1:0] POS_SENDER   = 8'd3;
    localparam logic [BYTE_W-1:0] POS_SEQ      = 8'd4;

    // register indexes
    localparam logic [1:0] REG_MAGIC    = 2'd0;
    localparam logic [1:0] REG_VERSION  = 2'd1;
    localparam logic [1:0] REG_ACK_TYPE = 2'd2;
    localparam logic [1:0] REG_SENDER   = 2'd3;

    localparam logic [BYTE_W-1:0] MAGIC_RESET    = 8'hA5;
    localparam logic [BYTE_W-1:0] VERSION_RESET  = 8'h01;
    localparam logic [BYTE_W-1:0] ACK_TYPE_RESET = 8'h20;
    localparam logic [BYTE_W-1:0] SENDER_RESET   = 8'hF0;

    typedef struct packed {
        logic [BYTE_W-1:0] magic_value;
        logic [BYTE_W-1:0] version_value;
        logic [BYTE_W-1:0] ack_type_value;
        logic [BYTE_W-1:0] sender_value;
    } akfc_cfg_t;

    // one byte of crc-16, msb first, unrolled over the eight bits
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### hw/rtl/ack_frame_checker_core.sv
// Acknowledgement frame checker. Takes one frame byte per beat on s_axis and gives one
// result beat on m_axis for the beat marked tlast: bit 0 pass/fail, bits 8:1 the frame
// length (saturating at 255). One byte is taken every cycle unless stalled; the
// rate is set by the unrolled eight-bit crc-16 step (poly 0x1021, init 0xFFFF) between
// the frame state registers and the result register. The result is registered from its
// last byte and held until m_axis_tready. s_axis_tready is low only while a result
// waits and m_axis_tready is low. Header values are set over the apb port at 0x0..0xC.
module ack_frame_checker_core
    import akfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // apb configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // byte stream in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] rx_byte, [15:8] expected_seq
    input  logic                  s_axis_tlast,  // frame_end
    // result out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [0] ack_ok, [8:1] frame_length, rest 0
);

    akfc_cfg_t cfg;

    logic [CRC_W-1:0]  crc_reg, crc_next, crc_upd;
    logic [BYTE_W-1:0] held0_reg, held0_next;
    logic [BYTE_W-1:0] held1_reg, held1_next;
    logic [BYTE_W-1:0] count_reg, count_next, count_inc;
    logic              hdr_good_reg, hdr_good_next, hdr_good_upd;
    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    logic [BYTE_W-1:0] out_len_reg, out_len_next;

    logic              in_beat;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] expected_seq;
    logic [BYTE_W-1:0] want;
    logic              frame_ok;

    akfc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign rx_byte       = s_axis_tdata[BYTE_W-1:0];
    assign expected_seq  = s_axis_tdata[2*BYTE_W-1:BYTE_W];
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        case (count_reg)
            POS_MAGIC:    want = cfg.magic_value;
            POS_VERSION:  want = cfg.version_value;
            POS_ACK_TYPE: want = cfg.ack_type_value;
            POS_SENDER:   want = cfg.sender_value;
            POS_SEQ:      want = expected_seq;
            default:      want = PAD_BYTE;
        endcase
    end

    // the two newest bytes are the trailer, so crc runs two bytes behind
    assign crc_upd      = (count_reg >= 8'd2) ? crc_byte(crc_reg, held0_reg) : crc_reg;
    assign hdr_good_upd = hdr_good_reg && ((count_reg >= HEADER_BYTES) || (rx_byte == want));
    assign count_inc    = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;
    assign frame_ok     = hdr_good_upd
                          && (count_inc >= MIN_FRAME_BYTES)
                          && (count_inc >= HEADER_BYTES)
                          && ({held1_reg, rx_byte} == crc_upd);

    always_comb
    begin
        crc_next       = crc_reg;
        held0_next     = held0_reg;
        held1_next     = held1_reg;
        count_next     = count_reg;
        hdr_good_next  = hdr_good_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_ok_next    = out_ok_reg;
        out_len_next   = out_len_reg;
        if (in_beat)
        begin
            if (s_axis_tlast)
            begin
                crc_next       = CRC_INIT;
                held0_next     = '0;
                held1_next     = '0;
                count_next     = '0;
                hdr_good_next  = 1'b1;
                out_valid_next = 1'b1;
                out_ok_next    = frame_ok;
                out_len_next   = count_inc;
            end
            else
            begin
                crc_next      = crc_upd;
                held0_next    = held1_reg;
                held1_next    = rx_byte;
                count_next    = count_inc;
                hdr_good_next = hdr_good_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            held0_reg     <= '0;
            held1_reg     <= '0;
            count_reg     <= '0;
            hdr_good_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            held0_reg     <= held0_next;
            held1_reg     <= held1_next;
            count_reg     <= count_next;
            hdr_good_reg  <= hdr_good_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_ok_reg  <= out_ok_next;
        out_len_reg <= out_len_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-BYTE_W-1){1'b0}}, out_len_reg, out_ok_reg};

endmodule

### hw/rtl/akfc_cfg_regs.sv
// apb register file holding the expected header values
module akfc_cfg_regs
    import akfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output akfc_cfg_t             cfg
);

    akfc_cfg_t   cfg_reg;
    akfc_cfg_t   cfg_next;
    logic        wr_en;
    logic [1:0]  reg_idx;
    logic [BYTE_W-1:0] wr_byte;
    logic [BYTE_W-1:0] rd_byte;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign wr_byte = pwdata[BYTE_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MAGIC:    cfg_next.magic_value    = wr_byte;
                REG_VERSION:  cfg_next.version_value  = wr_byte;
                REG_ACK_TYPE: cfg_next.ack_type_value = wr_byte;
                REG_SENDER:   cfg_next.sender_value   = wr_byte;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MAGIC:    rd_byte = cfg_reg.magic_value;
            REG_VERSION:  rd_byte = cfg_reg.version_value;
            REG_ACK_TYPE: rd_byte = cfg_reg.ack_type_value;
            REG_SENDER:   rd_byte = cfg_reg.sender_value;
            default:      rd_byte = '0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, rd_byte};
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_value    <= MAGIC_RESET;
            cfg_reg.version_value  <= VERSION_RESET;
            cfg_reg.ack_type_value <= ACK_TYPE_RESET;
            cfg_reg.sender_value   <= SENDER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hw/rtl/akfc_checker.sv
// port-level checks for the ack frame checker, bound to the top level
module akfc_checker
    import akfc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // input side only blocks while a result is stuck
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // every new result comes from a last byte taken the cycle before
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready)
        |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("result without a last byte");

    // a pass needs at least the minimum length
    a_pass_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[8:1] >= MIN_FRAME_BYTES)
        else $error("pass reported on a short frame");

endmodule

bind ack_frame_checker_core akfc_checker u_akfc_checker (.*);

### tb/tb_ack_frame_checker_core.sv
// testbench for the ack frame checker: result tracker class, stream and apb drivers
`timescale 1ns / 1ps

module tb_ack_frame_checker_core;
    import akfc_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;

    typedef struct packed {
        logic              ack_ok;
        logic [BYTE_W-1:0] length;
    } ack_result_t;

    // predicts the verdict of each frame and keeps the verdicts not yet seen on m_axis
    class ack_result_tracker;
        logic [BYTE_W-1:0] hdr_magic;
        logic [BYTE_W-1:0] hdr_version;
        logic [BYTE_W-1:0] hdr_type;
        logic [BYTE_W-1:0] hdr_sender;
        logic [CRC_W-1:0]  crc_run;
        logic [BYTE_W-1:0] delay_line [2];
        logic [BYTE_W-1:0] rx_count;
        logic              hdr_match;
        ack_result_t       expected_acks [$];
        int unsigned       errors;

        function new();
            hdr_magic   = MAGIC_RESET;
            hdr_version = VERSION_RESET;
            hdr_type    = ACK_TYPE_RESET;
            hdr_sender  = SENDER_RESET;
            errors      = 0;
            restart_frame();
        endfunction

        // bit-serial form of the msb-first crc
        static function logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] c,
                                                     input logic [BYTE_W-1:0] b);
            logic fb;
            for (int i = BYTE_W - 1; i >= 0; i--)
            begin
                fb = c[CRC_W-1] ^ b[i];
                c  = {c[CRC_W-2:0], 1'b0};
                if (fb)
                    c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function void restart_frame();
            crc_run       = CRC_INIT;
            delay_line[0] = '0;
            delay_line[1] = '0;
            rx_count      = '0;
            hdr_match     = 1'b1;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [BYTE_W-1:0] val);
            case (idx)
                REG_MAGIC:    hdr_magic   = val;
                REG_VERSION:  hdr_version = val;
                REG_ACK_TYPE: hdr_type    = val;
                REG_SENDER:   hdr_sender  = val;
                default:      ;
            endcase
        endfunction

        function void take_byte(input logic [BYTE_W-1:0] b, input logic last,
                                input logic [BYTE_W-1:0] seq);
            logic [BYTE_W-1:0] want;
            ack_result_t       r;
            if (rx_count < HEADER_BYTES)
            begin
                case (rx_count)
                    POS_MAGIC:    want = hdr_magic;
                    POS_VERSION:  want = hdr_version;
                    POS_ACK_TYPE: want = hdr_type;
                    POS_SENDER:   want = hdr_sender;
                    POS_SEQ:      want = seq;
                    default:      want = PAD_BYTE;
                endcase
                if (b != want)
                    hdr_match = 1'b0;
            end
            // the two newest bytes stay out of the crc until they are pushed out
            if (rx_count >= 2)
                crc_run = crc_update(crc_run, delay_line[0]);
            delay_line[0] = delay_line[1];
            delay_line[1] = b;
            if (rx_count != COUNT_MAX)
                rx_count = rx_count + 1'b1;
            if (last)
            begin
                r.ack_ok = hdr_match && (rx_count >= MIN_FRAME_BYTES)
                           && (rx_count >= HEADER_BYTES)
                           && ({delay_line[0], delay_line[1]} == crc_run);
                r.length = rx_count;
                expected_acks.push_back(r);
                restart_frame();
            end
        endfunction

        function void match_result(input logic [OUT_DATA_W-1:0] data);
            ack_result_t exp_r;
            if (expected_acks.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, tdata=%h", $time, data);
                errors++;
                return;
            end
            exp_r = expected_acks.pop_front();
            if (data[0] !== exp_r.ack_ok)
            begin
                $display("%0t: ack_ok expected %0d actual %0d", $time, exp_r.ack_ok, data[0]);
                errors++;
            end
            if (data[8:1] !== exp_r.length)
            begin
                $display("%0t: frame_length expected %0d actual %0d",
                         $time, exp_r.length, data[8:1]);
                errors++;
            end
            if (data[OUT_DATA_W-1:9] !== '0)
            begin
                $display("%0t: pad bits expected 0 actual %h", $time, data[OUT_DATA_W-1:9]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [7:0] rx_byte, [15:8] expected_seq
    logic                  s_axis_tlast;   // frame_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [0] ack_ok, [8:1] frame_length, rest 0

    ack_result_tracker  tracker;
    logic [BYTE_W-1:0]  frame_bytes [$];
    int unsigned        items_sent;
    int unsigned        idle_cycles;
    bit                 src_burst;
    bit                 snk_burst;

    ack_frame_checker_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic apb_write(input logic [1:0] idx, input logic [BYTE_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // upper data bits are junk, the block keeps only the low byte
        pwdata  <= {24'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_reg(idx, val);
    endtask

    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last,
                             input logic [BYTE_W-1:0] seq);
        int unsigned gap;
        gap = src_burst ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {seq, b};
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        tracker.take_byte(b, last, seq);
        items_sent++;
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] seq);
        foreach (frame_bytes[i])
            send_beat(frame_bytes[i], i == frame_bytes.size() - 1, seq);
        if ($urandom_range(0, 7) == 0)
            src_burst = !src_burst;
    endtask

    // header from the current register values, random payload, trailing crc big-endian
    task automatic build_frame(input int unsigned payload_len, input logic [BYTE_W-1:0] seq,
                               input bit bad_hdr, input bit bad_crc);
        int unsigned      pos;
        logic [CRC_W-1:0] c;
        frame_bytes.delete();
        frame_bytes.push_back(tracker.hdr_magic);
        frame_bytes.push_back(tracker.hdr_version);
        frame_bytes.push_back(tracker.hdr_type);
        frame_bytes.push_back(tracker.hdr_sender);
        frame_bytes.push_back(seq);
        frame_bytes.push_back(PAD_BYTE);
        repeat (payload_len) frame_bytes.push_back(8'($urandom));
        if (bad_hdr)
        begin
            pos = $urandom_range(0, HEADER_BYTES - 1);
            frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
        end
        c = CRC_INIT;
        foreach (frame_bytes[i])
            c = ack_result_tracker::crc_update(c, frame_bytes[i]);
        if (bad_crc)
            c = c ^ 16'($urandom_range(1, 16'hFFFF));
        frame_bytes.push_back(c[15:8]);
        frame_bytes.push_back(c[7:0]);
    endtask

    function automatic logic [BYTE_W-1:0] pick_reg_value(input int unsigned phase);
        if (phase == 1)
            return 8'h00;
        else if (phase == 2)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // result side: random stall before each beat, with stretches of none
    initial
    begin
        int unsigned stall;
        m_axis_tready = 1'b0;
        forever
        begin
            stall = snk_burst ? 0 : $urandom_range(0, 16);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            if ($urandom_range(0, 9) == 0)
                snk_burst = !snk_burst;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_result(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned       sel;
        int unsigned       cut;
        int unsigned       target;
        logic [BYTE_W-1:0] seq;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        items_sent    = 0;
        idle_cycles   = 0;
        src_burst     = 1'b0;
        snk_burst     = 1'b0;
        tracker       = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // minimum-length good frame, then short frames, then a crc mismatch
        build_frame(0, 8'hFF, 1'b0, 1'b0);
        send_frame(8'hFF);
        frame_bytes = '{8'hFF};
        send_frame(8'h00);
        frame_bytes = '{8'h00, 8'h00, 8'h00};
        send_frame(8'h00);
        build_frame(2, 8'h00, 1'b0, 1'b1);
        send_frame(8'h00);

        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase != 0)
            begin
                s_axis_tvalid <= 1'b0;
                while (tracker.expected_acks.size() != 0) @(posedge clk);
                repeat (4) @(posedge clk);
                apb_write(REG_MAGIC, pick_reg_value(phase));
                apb_write(REG_VERSION, pick_reg_value(phase));
                apb_write(REG_ACK_TYPE, pick_reg_value(phase));
                apb_write(REG_SENDER, pick_reg_value(phase));
                psel    <= 1'b0;
                penable <= 1'b0;
                pwrite  <= 1'b0;
                @(posedge clk);
            end
            target = items_sent + 240;
            // length counter saturates on these
            if (phase == 0 || phase == 4)
            begin
                seq = 8'($urandom);
                build_frame(250, seq, 1'b0, phase == 4);
                send_frame(seq);
            end
            while (items_sent < target)
            begin
                sel = $urandom_range(0, 99);
                seq = 8'($urandom);
                if (sel < 70)
                    build_frame($urandom_range(0, 12), seq, $urandom_range(0, 9) == 0,
                                $urandom_range(0, 6) == 0);
                else if (sel < 85)
                begin
                    // well-formed frame cut short
                    build_frame($urandom_range(0, 4), seq, 1'b0, 1'b0);
                    cut = $urandom_range(1, frame_bytes.size() - 1);
                    repeat (cut) void'(frame_bytes.pop_back());
                end
                else
                begin
                    frame_bytes.delete();
                    repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
                end
                send_frame(seq);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (tracker.expected_acks.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.expected_acks.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, tracker.expected_acks.size());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
